FILE: design/nps_pkg.sv
package nps_pkg;

  localparam int unsigned DefaultValueBits = 31;
  localparam int unsigned SquareBits       = 32;
  localparam int unsigned RootBits         = 16;

  typedef struct packed {
    logic valid;
    logic advance;
  } nps_ctrl_t;

endpackage

FILE: design/nps_stage.sv
module nps_stage #(
  parameter int unsigned W      = 32,
  parameter int unsigned BIT_POS = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  nps_pkg::nps_ctrl_t  ctrl_i,
  input  logic [W-1:0]        value_i,
  input  logic [W-1:0]        rem_i,
  input  logic [W-1:0]        res_i,
  output logic                valid_o,
  output logic [W-1:0]        value_o,
  output logic [W-1:0]        rem_o,
  output logic [W-1:0]        res_o
);

  localparam logic [W:0] Bit = (W+1)'(1) << BIT_POS;

  logic         valid_q;
  logic [W-1:0] value_q, rem_q, res_q;
  logic [W-1:0] rem_d, res_d;
  logic [W:0]   trial;
  logic         take;

  always_comb begin
    trial = {1'b0, res_i} + Bit;
    take  = ({1'b0, rem_i} >= trial);
    if (take) begin
      rem_d = rem_i - trial[W-1:0];
      res_d = (res_i >> 1) + Bit[W-1:0];
    end else begin
      rem_d = rem_i;
      res_d = res_i >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.advance) begin
      valid_q <= ctrl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.advance) begin
      value_q <= value_i;
      rem_q   <= rem_d;
      res_q   <= res_d;
    end
  end

  assign valid_o = valid_q;
  assign value_o = value_q;
  assign rem_o   = rem_q;
  assign res_o   = res_q;

endmodule

FILE: design/nearest_perfect_square_top.sv
// An accepted input beat passes through the root stages and the output register to
// become its result beat; the default width is 31 bits. One root bit is resolved
// per pipeline stage. Throughput: one beat per cycle while the output is not stalled.
// A stalled output register holds the whole pipeline in place.
// Reset is asynchronous and active low; it clears only the valid bits.
module nearest_perfect_square_top #(
  parameter int unsigned VALUE_BITS = nps_pkg::DefaultValueBits
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [VALUE_BITS-1:0]            value_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [nps_pkg::SquareBits-1:0]   square_o,
  output logic [nps_pkg::RootBits-1:0]     root_o
);

  localparam int unsigned RB  = (VALUE_BITS + 1) / 2;
  localparam int unsigned W   = 2 * RB;
  localparam int unsigned SQW = (W + 1 > nps_pkg::SquareBits) ? W + 1 : nps_pkg::SquareBits;
  localparam int unsigned RTW = (RB + 1 > nps_pkg::RootBits) ? RB + 1 : nps_pkg::RootBits;

  logic         advance;
  logic         valid_s [RB+1];
  logic [W-1:0] value_s [RB+1];
  logic [W-1:0] rem_s   [RB+1];
  logic [W-1:0] res_s   [RB+1];

  assign advance    = !out_valid_o || out_ready_i;
  assign in_ready_o = advance;

  assign valid_s[0] = in_valid_i;
  assign value_s[0] = W'(value_i);
  assign rem_s[0]   = W'(value_i);
  assign res_s[0]   = '0;

  for (genvar i = 0; i < RB; i++) begin : g_stage
    nps_pkg::nps_ctrl_t ctrl;
    assign ctrl.valid   = valid_s[i];
    assign ctrl.advance = advance;

    nps_stage #(
      .W      (W),
      .BIT_POS(2 * (RB - 1 - i))
    ) u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .value_i(value_s[i]),
      .rem_i  (rem_s[i]),
      .res_i  (res_s[i]),
      .valid_o(valid_s[i+1]),
      .value_o(value_s[i+1]),
      .rem_o  (rem_s[i+1]),
      .res_o  (res_s[i+1])
    );
  end

  logic           out_valid_q;
  logic           round_up;
  logic [W:0]     root_rnd;
  logic [W:0]     square_rnd;
  logic [SQW-1:0] square_ext;
  logic [RTW-1:0] root_ext;
  logic [nps_pkg::SquareBits-1:0] square_d, square_q;
  logic [nps_pkg::RootBits-1:0]   root_d, root_q;

  always_comb begin
    round_up   = (rem_s[RB] > res_s[RB]);
    root_rnd   = {1'b0, res_s[RB]} + (W+1)'(round_up);
    square_rnd = {1'b0, value_s[RB] - rem_s[RB]};
    if (round_up) begin
      square_rnd = square_rnd + ({1'b0, res_s[RB]} << 1) + (W+1)'(1);
    end
    square_ext = SQW'(square_rnd);
    root_ext   = RTW'(root_rnd[RB:0]);
    square_d   = square_ext[nps_pkg::SquareBits-1:0];
    root_d     = root_ext[nps_pkg::RootBits-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= valid_s[RB];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      square_q <= square_d;
      root_q   <= root_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign square_o    = square_q;
  assign root_o      = root_q;

endmodule

FILE: design/nps_checker.sv
module nps_checker #(
  parameter int unsigned VALUE_BITS = nps_pkg::DefaultValueBits
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input logic [VALUE_BITS-1:0]          value_i,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic [nps_pkg::SquareBits-1:0] square_o,
  input logic [nps_pkg::RootBits-1:0]   root_o
);

  // A result beat that is held back keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(square_o) && $stable(root_o))
    else $error("stalled result beat changed");

  // An input beat that is held back keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(value_i))
    else $error("stalled input beat changed");

  // The input side is open exactly when the output register can move.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("input ready does not follow output register state");

  // At widths where the root fits its field, the square is the root squared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (VALUE_BITS > 32) ||
      (square_o == 32'(32'(root_o) * 32'(root_o))))
    else $error("square does not match root");

  // Reset leaves no result beat pending.
  assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("result valid during reset");

endmodule

bind nearest_perfect_square_top nps_checker #(
  .VALUE_BITS(VALUE_BITS)
) u_nps_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .value_i    (value_i),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .square_o   (square_o),
  .root_o     (root_o)
);
